// File: design/gmd_pkg.sv
// Shared constants, types and control structs of the gradient magnitude and direction unit.
// Depends on nothing; every other file of the block uses it.
package gmd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ADDR_W     = COL_W + 1;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int W_W        = $clog2(MAX_WIDTH + 1);
	localparam int H_W        = $clog2(MAX_HEIGHT + 1);

	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

	localparam int SQ_W       = 16;
	localparam int SUM_W      = 17;
	localparam int QUO_W      = 29;
	localparam int SQ_RAD_W   = 30;
	localparam int SQ_ROOT_W  = 15;
	localparam int SQRT_STEPS = 15;
	localparam int DIV_STEPS  = QUO_W;
	localparam int SQ_CNT_W   = $clog2(SQRT_STEPS + 1);
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
	localparam int MAG_W      = 13;
	localparam int DIR_W      = 16;
	localparam logic [SQ_ROOT_W-1:0] UNIT_ONE = SQ_ROOT_W'(16384);

	typedef enum logic [1:0] {
		CAP_LEFT,
		CAP_RIGHT,
		CAP_MID,
		CAP_UP
	} cap_t;

	typedef struct packed {
		logic              mem_rd;
		logic              mem_we;
		logic [ADDR_W-1:0] mem_addr;
		logic              cap_en;
		cap_t              cap;
		logic              pix_ld;
		logic              down_pix;
		logic              mul;
		logic              sq_start;
		logic              sq_mag;
		logic              div_start;
		logic              div_x;
		logic              st_mag;
		logic              st_dir_y;
		logic              st_dir_x;
		logic              zero_dir;
		logic              out_load;
		logic              frame_end;
	} cmd_t;

	typedef struct packed {
		logic sq_done;
		logic div_done;
		logic sum_zero;
	} sts_t;

endpackage

// File: design/gmd_if.sv
// Handshake channel interfaces of the gradient unit: pixel requests, results, register writes.
// Depends on gmd_pkg for field widths.
interface gmd_in_if;
	logic             valid;
	logic             ready;
	logic             func;
	logic [7:0]       pixel;
	modport source (output valid, output func, output pixel, input ready);
	modport sink   (input valid, input func, input pixel, output ready);
endinterface

interface gmd_out_if;
	logic                     valid;
	logic                     ready;
	logic signed [8:0]        grad_x;
	logic signed [8:0]        grad_y;
	logic [gmd_pkg::MAG_W-1:0] magnitude;
	logic signed [gmd_pkg::DIR_W-1:0] dir_x;
	logic signed [gmd_pkg::DIR_W-1:0] dir_y;
	logic                     frame_end;
	modport source (output valid, output grad_x, output grad_y, output magnitude,
		output dir_x, output dir_y, output frame_end, input ready);
	modport sink   (input valid, input grad_x, input grad_y, input magnitude,
		input dir_x, input dir_y, input frame_end, output ready);
endinterface

interface gmd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [gmd_pkg::CFG_IDX_W-1:0] index;
	logic [gmd_pkg::CFG_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/gradient_magnitude_direction_unit.sv
// Top level of the central-difference gradient, magnitude and edge direction unit.
// Depends on gmd_pkg, gmd_if, gmd_ctrl and gmd_dp.
//
// Pixels enter in raster order and each result leaves one row late; flush requests drain
// the last row, and the final flush carries frame_end. A request that yields a result
// runs four line-store reads over the single memory port, one write for a pixel, a multiply
// step, a 15-step square root for the magnitude and, for a nonzero gradient, a 29-step
// divide and a 15-step root for each direction component, all on one shared root unit and
// one divider, and then loads the result register. With a zero gradient the directions are
// skipped. A pixel of the first row only writes the line store, and an ignored request does
// nothing. The result register stalls the sequencer only when it still holds an unaccepted
// result at load time. A new request is accepted while the previous result still waits on
// the result channel.
module gradient_magnitude_direction_unit (
	input  logic      clk,
	input  logic      arst_n,
	gmd_in_if.sink    pixels,
	gmd_out_if.source results,
	gmd_cfg_if.sink   cfg
);
	import gmd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixels.valid),
		.in_func   (pixels.func),
		.in_ready  (pixels.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cfg_ready (cfg.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	gmd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixels.pixel),
		.cmd       (cmd),
		.sts       (sts),
		.grad_x    (results.grad_x),
		.grad_y    (results.grad_y),
		.magnitude (results.magnitude),
		.dir_x     (results.dir_x),
		.dir_y     (results.dir_y),
		.frame_end (results.frame_end)
	);

	a_zero_mag_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.magnitude == '0 |-> results.dir_x == '0 && results.dir_y == '0)
		else $error("zero magnitude with nonzero direction");

	a_mag_has_dir: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.magnitude != '0 |-> results.dir_x != '0 || results.dir_y != '0)
		else $error("nonzero magnitude without direction");

	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> !cmd.mem_rd && !pixels.ready)
		else $error("line store write collides with a read or a new request");
endmodule

// File: design/gmd_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on gmd_pkg.
module gmd_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [gmd_pkg::SQ_RAD_W-1:0]   radicand,
	output logic [gmd_pkg::SQ_ROOT_W-1:0]  root,
	output logic                           done
);
	import gmd_pkg::*;

	logic                  busy_q, done_q;
	logic [SQ_CNT_W-1:0]   cnt_q;
	logic [SQ_RAD_W-1:0]   rad_q;
	logic [SQ_ROOT_W+1:0]  rem_q;
	logic [SQ_ROOT_W-1:0]  root_q;
	logic [SQ_ROOT_W+3:0]  remx, trial;
	logic                  fits;

	assign remx  = {rem_q, rad_q[SQ_RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = remx >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CNT_W'(SQRT_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - SQ_CNT_W'(1);
				if (cnt_q == SQ_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= (SQ_ROOT_W+2)'(remx - trial);
				root_q <= {root_q[SQ_ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= (SQ_ROOT_W+2)'(remx);
				root_q <= {root_q[SQ_ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

// File: design/gmd_div.sv
// Restoring divider for (a*a << 28) / sum, one quotient bit per cycle.
// Depends on gmd_pkg; the caller guarantees a*a <= sum and sum > 0.
module gmd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gmd_pkg::SQ_W-1:0]    square,
	input  logic [gmd_pkg::SUM_W-1:0]   sum,
	output logic [gmd_pkg::QUO_W-1:0]   quotient,
	output logic                        done
);
	import gmd_pkg::*;

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     den_q, rem_q;
	logic [QUO_W-1:0]     nb_q, quo_q;
	logic [SUM_W:0]       remx;
	logic                 fits;

	assign remx = {rem_q, nb_q[QUO_W-1]};
	assign fits = remx >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The low 28 dividend bits are zero, so only the square's LSB is shifted in.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= sum;
			rem_q <= SUM_W'(square >> 1);
			nb_q  <= {square[0], {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			nb_q <= nb_q << 1;
			if (fits) begin
				rem_q <= SUM_W'(remx - {1'b0, den_q});
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= SUM_W'(remx);
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

// File: design/gmd_ctrl.sv
// Controller: register file, raster counters and the sequencer of one request.
// Depends on gmd_pkg; drives gmd_dp through cmd_t and reads sts_t.
module gmd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_func,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          cfg_valid,
	input  logic [gmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gmd_pkg::CFG_W-1:0]     cfg_data,
	output logic                          cfg_ready,
	output gmd_pkg::cmd_t                 cmd,
	input  gmd_pkg::sts_t                 sts
);
	import gmd_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RD0   = 5'd1;
	localparam logic [4:0] S_RD1   = 5'd2;
	localparam logic [4:0] S_RD2   = 5'd3;
	localparam logic [4:0] S_RD3   = 5'd4;
	localparam logic [4:0] S_RD4   = 5'd5;
	localparam logic [4:0] S_WR    = 5'd6;
	localparam logic [4:0] S_MUL   = 5'd7;
	localparam logic [4:0] S_MAGGO = 5'd8;
	localparam logic [4:0] S_MAGW  = 5'd9;
	localparam logic [4:0] S_DXGO  = 5'd10;
	localparam logic [4:0] S_DXW   = 5'd11;
	localparam logic [4:0] S_SXGO  = 5'd12;
	localparam logic [4:0] S_SXW   = 5'd13;
	localparam logic [4:0] S_DYGO  = 5'd14;
	localparam logic [4:0] S_DYW   = 5'd15;
	localparam logic [4:0] S_SYGO  = 5'd16;
	localparam logic [4:0] S_SYW   = 5'd17;
	localparam logic [4:0] S_OUT   = 5'd18;

	logic [4:0]       state_q, state_d;
	logic [CFG_W-1:0] fw_q, fh_q;
	logic [COL_W-1:0] col_q, flush_q;
	logic [ROW_W-1:0] row_q;
	logic             drain_q, out_valid_q;

	logic [COL_W-1:0] c_q, lc_q, rc_q;
	logic             qpar_q, qpos_q, wpar_q, emit_q, we_q, last_q, flush_item_q;

	logic [W_W-1:0]   wc;
	logic [H_W-1:0]   hc;
	logic [COL_W-1:0] cc, c_pix, c_fl;
	logic [ROW_W-1:0] q;
	logic             last, accept, emit, wr, row_end;

	always_comb begin
		if (fw_q == '0) wc = W_W'(1);
		else if (32'(fw_q) > MAX_WIDTH) wc = W_W'(MAX_WIDTH);
		else wc = W_W'(fw_q);
		if (fh_q == '0) hc = H_W'(1);
		else if (32'(fh_q) > MAX_HEIGHT) hc = H_W'(MAX_HEIGHT);
		else hc = H_W'(fh_q);
	end

	assign c_pix   = (W_W'(col_q) < wc) ? col_q : COL_W'(wc - W_W'(1));
	assign c_fl    = (W_W'(flush_q) < wc) ? flush_q : COL_W'(wc - W_W'(1));
	assign cc      = in_func ? c_fl : c_pix;
	assign last    = (W_W'(cc) + W_W'(1)) >= wc;
	assign row_end = (H_W'(row_q) + H_W'(1)) >= hc;
	assign accept  = in_valid && in_ready;
	// A flush outside a drain and a pixel during a drain both do nothing.
	assign emit    = in_func ? drain_q : (!drain_q && row_q != '0);
	assign wr      = !in_func && !drain_q;
	assign q       = in_func ? row_q : row_q - ROW_W'(1);

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_FRAME_WIDTH) fw_q <= cfg_data;
			if (cfg_index == REG_FRAME_HEIGHT) fh_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			flush_q     <= '0;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (accept) begin
				if (in_func) begin
					if (drain_q) begin
						if (last) begin
							drain_q <= 1'b0;
							row_q   <= '0;
							col_q   <= '0;
							flush_q <= '0;
						end else begin
							flush_q <= cc + COL_W'(1);
						end
					end
				end else if (!drain_q) begin
					if (last) begin
						col_q <= '0;
						if (row_end) begin
							drain_q <= 1'b1;
							flush_q <= '0;
						end else begin
							row_q <= row_q + ROW_W'(1);
						end
					end else begin
						col_q <= cc + COL_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q          <= cc;
			lc_q         <= (cc != '0) ? cc - COL_W'(1) : cc;
			rc_q         <= last ? cc : cc + COL_W'(1);
			qpar_q       <= q[0];
			qpos_q       <= q != '0;
			wpar_q       <= row_q[0];
			emit_q       <= emit;
			we_q         <= wr;
			last_q       <= in_func && last;
			flush_item_q <= in_func;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.cap       = CAP_LEFT;
		cmd.frame_end = last_q;
		cmd.down_pix  = !flush_item_q;
		cmd.pix_ld    = accept;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (emit) state_d = S_RD0;
					else if (wr) state_d = S_WR;
				end
			end
			S_RD0: begin
				cmd.mem_rd   = 1'b1;
				cmd.mem_addr = {qpar_q, lc_q};
				state_d      = S_RD1;
			end
			S_RD1: begin
				cmd.mem_rd   = 1'b1;
				cmd.mem_addr = {qpar_q, rc_q};
				cmd.cap_en   = 1'b1;
				cmd.cap      = CAP_LEFT;
				state_d      = S_RD2;
			end
			S_RD2: begin
				cmd.mem_rd   = 1'b1;
				cmd.mem_addr = {qpar_q, c_q};
				cmd.cap_en   = 1'b1;
				cmd.cap      = CAP_RIGHT;
				state_d      = S_RD3;
			end
			S_RD3: begin
				// On the first row the upper neighbor is the pixel itself.
				cmd.mem_rd   = 1'b1;
				cmd.mem_addr = {qpos_q ? !qpar_q : qpar_q, c_q};
				cmd.cap_en   = 1'b1;
				cmd.cap      = CAP_MID;
				state_d      = S_RD4;
			end
			S_RD4: begin
				cmd.cap_en = 1'b1;
				cmd.cap    = CAP_UP;
				state_d    = we_q ? S_WR : S_MUL;
			end
			S_WR: begin
				cmd.mem_we   = 1'b1;
				cmd.mem_addr = {wpar_q, c_q};
				state_d      = emit_q ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_MAGGO;
			end
			S_MAGGO: begin
				cmd.sq_start = 1'b1;
				cmd.sq_mag   = 1'b1;
				state_d      = S_MAGW;
			end
			S_MAGW: begin
				if (sts.sq_done) begin
					cmd.st_mag = 1'b1;
					if (sts.sum_zero) begin
						cmd.zero_dir = 1'b1;
						state_d      = S_OUT;
					end else begin
						state_d = S_DXGO;
					end
				end
			end
			S_DXGO: begin
				cmd.div_start = 1'b1;
				cmd.div_x     = 1'b1;
				state_d       = S_DXW;
			end
			S_DXW: if (sts.div_done) state_d = S_SXGO;
			S_SXGO: begin
				cmd.sq_start = 1'b1;
				state_d      = S_SXW;
			end
			S_SXW: begin
				if (sts.sq_done) begin
					cmd.st_dir_y = 1'b1;
					state_d      = S_DYGO;
				end
			end
			S_DYGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DYW;
			end
			S_DYW: if (sts.div_done) state_d = S_SYGO;
			S_SYGO: begin
				cmd.sq_start = 1'b1;
				state_d      = S_SYW;
			end
			S_SYW: begin
				if (sts.sq_done) begin
					cmd.st_dir_x = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// File: design/gmd_dp.sv
// Datapath: two-row line store, neighbor registers, gradient products, root and divider units.
// Depends on gmd_pkg, gmd_isqrt and gmd_div; steered by gmd_ctrl through cmd_t.
module gmd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        pixel,
	input  gmd_pkg::cmd_t                     cmd,
	output gmd_pkg::sts_t                     sts,
	output logic signed [8:0]                 grad_x,
	output logic signed [8:0]                 grad_y,
	output logic [gmd_pkg::MAG_W-1:0]         magnitude,
	output logic signed [gmd_pkg::DIR_W-1:0]  dir_x,
	output logic signed [gmd_pkg::DIR_W-1:0]  dir_y,
	output logic                              frame_end
);
	import gmd_pkg::*;

	logic [7:0] mem [2*MAX_WIDTH];
	logic [7:0] rdata_q, pix_q, left_q, right_q, mid_q, up_q;
	logic signed [8:0] dx_q, dy_q, dx, dy, down;
	logic signed [17:0] px2, py2;
	logic [SQ_W-1:0]  ax2_q, ay2_q;
	logic [SUM_W-1:0] sum;
	logic [MAG_W-1:0] mag_q;
	logic signed [DIR_W-1:0] dir_x_q, dir_y_q, unit_pos;
	logic [SQ_ROOT_W-1:0] root, sat;
	logic [QUO_W-1:0] quo;
	logic [SQ_RAD_W-1:0] rad;
	logic sq_done, div_done;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) mem[cmd.mem_addr] <= pix_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) rdata_q <= mem[cmd.mem_addr];
	end

	assign down = signed'({1'b0, cmd.down_pix ? pix_q : mid_q});
	assign dx   = signed'({1'b0, right_q}) - signed'({1'b0, left_q});
	assign dy   = down - signed'({1'b0, up_q});
	assign px2  = dx * dx;
	assign py2  = dy * dy;
	assign sum  = SUM_W'(ax2_q) + SUM_W'(ay2_q);
	assign rad  = cmd.sq_mag ? {5'b0, sum, 8'b0} : {1'b0, quo};
	assign sat  = (root > UNIT_ONE) ? UNIT_ONE : root;
	assign unit_pos = DIR_W'(sat);

	always_ff @(posedge clk) begin
		if (cmd.pix_ld) pix_q <= pixel;
		if (cmd.cap_en) begin
			unique case (cmd.cap)
				CAP_LEFT:  left_q  <= rdata_q;
				CAP_RIGHT: right_q <= rdata_q;
				CAP_MID:   mid_q   <= rdata_q;
				CAP_UP:    up_q    <= rdata_q;
			endcase
		end
		if (cmd.mul) begin
			dx_q  <= dx;
			dy_q  <= dy;
			ax2_q <= px2[SQ_W-1:0];
			ay2_q <= py2[SQ_W-1:0];
		end
		if (cmd.st_mag) mag_q <= root[MAG_W-1:0];
		if (cmd.zero_dir) begin
			dir_x_q <= '0;
			dir_y_q <= '0;
		end
		if (cmd.st_dir_y) dir_y_q <= dx_q[8] ? -unit_pos : unit_pos;
		if (cmd.st_dir_x) dir_x_q <= dy_q[8] ? unit_pos : -unit_pos;
		if (cmd.out_load) begin
			grad_x    <= dx_q;
			grad_y    <= dy_q;
			magnitude <= mag_q;
			dir_x     <= dir_x_q;
			dir_y     <= dir_y_q;
			frame_end <= cmd.frame_end;
		end
	end

	gmd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (rad),
		.root     (root),
		.done     (sq_done)
	);

	gmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.square   (cmd.div_x ? ax2_q : ay2_q),
		.sum      (sum),
		.quotient (quo),
		.done     (div_done)
	);

	assign sts.sq_done  = sq_done;
	assign sts.div_done = div_done;
	assign sts.sum_zero = sum == '0;
endmodule

// File: sim/tb_gradient_magnitude_direction_unit.sv
// Self-checking testbench of the gradient magnitude and direction unit.
// Depends on gmd_pkg and the channel interfaces in gmd_if; drives whole frames of pixels and
// flush requests and checks every result against a predictor kept in a small scoreboard class.
`timescale 1ns / 100ps

module tb_gradient_magnitude_direction_unit;
	import gmd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 150;

	typedef struct packed {
		logic signed [8:0]       grad_x;
		logic signed [8:0]       grad_y;
		logic [MAG_W-1:0]        magnitude;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic                    frame_end;
	} gradient_t;

	class gradient_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		byte unsigned line_mem [2*MAX_WIDTH];
		int unsigned col_cnt, row_cnt, flush_cnt;
		bit draining;
		gradient_t pending_q [$];
		int mismatches;
		int checked;

		function new();
			width_reg = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			foreach (line_mem[i]) line_mem[i] = 0;
			col_cnt = 0;
			row_cnt = 0;
			flush_cnt = 0;
			draining = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_FRAME_WIDTH)
				width_reg = val;
			else if (idx == REG_FRAME_HEIGHT)
				height_reg = val;
		endfunction

		function int unsigned eff_width();
			int unsigned w;
			w = width_reg;
			if (w < 1) w = 1;
			if (w > MAX_WIDTH) w = MAX_WIDTH;
			return w;
		endfunction

		function int unsigned eff_height();
			int unsigned h;
			h = height_reg;
			if (h < 1) h = 1;
			if (h > MAX_HEIGHT) h = MAX_HEIGHT;
			return h;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned root, bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= root + bitv) begin
					v -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return root;
		endfunction

		function int pixel_at(int unsigned row, int unsigned col);
			return line_mem[(row & 1) * MAX_WIDTH + (col % MAX_WIDTH)];
		endfunction

		// Q1.14 share of one component in the vector length, truncated and capped at one.
		function longint unit_share(int num, longint unsigned sum);
			longint unsigned mag_sq, q;
			mag_sq = (num < 0) ? -num : num;
			q = int_sqrt(((mag_sq * mag_sq) << 28) / sum);
			if (q > 16384) q = 16384;
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		function void predict(int unsigned q, int unsigned c, int unsigned w, int down,
				bit last);
			int unsigned lc, rc;
			int up, gx, gy;
			longint unsigned sum;
			gradient_t r;
			lc = (c > 0) ? c - 1 : c;
			rc = (c + 1 < w) ? c + 1 : c;
			up = (q > 0) ? pixel_at(q - 1, c) : pixel_at(q, c);
			gx = pixel_at(q, rc) - pixel_at(q, lc);
			gy = down - up;
			sum = gx * gx + gy * gy;
			r.grad_x = 9'(gx);
			r.grad_y = 9'(gy);
			r.magnitude = MAG_W'(int_sqrt(sum * 256));
			r.dir_x = (sum != 0) ? DIR_W'(-unit_share(gy, sum)) : '0;
			r.dir_y = (sum != 0) ? DIR_W'(unit_share(gx, sum)) : '0;
			r.frame_end = last;
			pending_q.push_back(r);
		endfunction

		function void note_request(bit is_flush, byte unsigned pix);
			int unsigned w, h, c;
			bit last;
			w = eff_width();
			h = eff_height();
			if (is_flush) begin
				if (!draining) return;
				c = (flush_cnt < w) ? flush_cnt : w - 1;
				last = (c + 1 >= w);
				predict(row_cnt, c, w, pixel_at(row_cnt, c), last);
				if (last) begin
					draining = 0;
					row_cnt = 0;
					col_cnt = 0;
					flush_cnt = 0;
				end else begin
					flush_cnt = c + 1;
				end
				return;
			end
			if (draining) return;
			c = (col_cnt < w) ? col_cnt : w - 1;
			if (row_cnt >= 1)
				predict(row_cnt - 1, c, w, pix, 1'b0);
			line_mem[(row_cnt & 1) * MAX_WIDTH + c] = pix;
			if (c + 1 >= w) begin
				col_cnt = 0;
				if (row_cnt + 1 >= h) begin
					draining = 1;
					flush_cnt = 0;
				end else begin
					row_cnt++;
				end
			end else begin
				col_cnt = c + 1;
			end
		endfunction

		function void check_result(gradient_t got);
			gradient_t want;
			checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none expected: %p", $realtime, got);
				return;
			end
			want = pending_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch, expected %p, got %p", $realtime, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	gmd_in_if  pix_if ();
	gmd_out_if res_if ();
	gmd_cfg_if cfg_if ();

	gradient_magnitude_direction_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	gradient_scoreboard sb = new();
	bit no_idling;
	int idle_count;
	int frames_done;
	int pixel_mode;
	byte unsigned pattern [9];
	byte unsigned last_pixel;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		if (no_idling) return 0;
		roll = $urandom_range(99);
		if (roll < 60) return 0;
		if (roll < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// The receiver holds ready low for random stretches as well.
	initial begin
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			res_if.ready <= 1'b1;
			repeat ($urandom_range(12, 1)) @(posedge clk);
			if (pick_gap() > 0) begin
				res_if.ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (res_if.valid && res_if.ready)
			sb.check_result({res_if.grad_x, res_if.grad_y, res_if.magnitude,
				res_if.dir_x, res_if.dir_y, res_if.frame_end});
	end

	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready) || !arst_n) begin
			idle_count <= 0;
		end else begin
			idle_count <= idle_count + 1;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_request(bit is_flush, byte unsigned pix);
		int g;
		g = pick_gap();
		if (g > 0) begin
			pix_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.func <= is_flush;
		pix_if.pixel <= pix;
		do @(posedge clk); while (!pix_if.ready);
		sb.note_request(is_flush, pix);
	endtask

	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		while (sb.pending_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_frame_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		wait_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= REG_FRAME_WIDTH;
		cfg_if.data <= w;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(REG_FRAME_WIDTH, w);
		cfg_if.index <= REG_FRAME_HEIGHT;
		cfg_if.data <= h;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(REG_FRAME_HEIGHT, h);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic byte unsigned next_pixel(int k);
		case (pixel_mode)
			0: last_pixel = 8'($urandom_range(255));
			1: last_pixel = $urandom_range(1) ? 8'd255 : 8'd0;
			2: last_pixel = 8'(last_pixel + $urandom_range(6) - 3);
			default: last_pixel = pattern[k % 9];
		endcase
		return last_pixel;
	endfunction

	// Pixels until the last row is held, then flushes until the frame closes; a few stray
	// requests that the block must ignore are mixed in.
	task automatic finish_frame(int noise_pct);
		int k;
		k = 0;
		while (!sb.draining) begin
			if ($urandom_range(99) < noise_pct)
				send_request(1'b1, 8'($urandom_range(255)));
			send_request(1'b0, next_pixel(k));
			k++;
		end
		while (sb.draining) begin
			if ($urandom_range(99) < noise_pct)
				send_request(1'b0, 8'($urandom_range(255)));
			send_request(1'b1, 8'($urandom_range(255)));
		end
		frames_done++;
	endtask

	task automatic run_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int mode);
		write_frame_size(w, h);
		pixel_mode = mode;
		no_idling = ($urandom_range(3) == 0);
		finish_frame(5);
	endtask

	initial begin
		arst_n = 1'b0;
		pix_if.valid <= 1'b0;
		pix_if.func <= 1'b0;
		pix_if.pixel <= 8'd0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_FRAME_WIDTH;
		cfg_if.data <= '0;
		no_idling = 0;
		frames_done = 0;
		last_pixel = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A flush with no held row is ignored.
		send_request(1'b1, 8'd0);
		send_request(1'b1, 8'd255);

		// The 3x3 center sees full-scale steps in both directions, then the inverse.
		pattern = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd77, 8'd255, 8'd0, 8'd255, 8'd255};
		run_frame(3, 3, 3);
		foreach (pattern[i]) pattern[i] = 8'd255 - pattern[i];
		run_frame(3, 3, 3);
		run_frame(0, 0, 0);
		run_frame(40, 2, 1);
		run_frame(1, 12, 0);
		run_frame(4, 1, 1);

		// Shrink the frame in the middle of a row; both sizes take effect at once.
		write_frame_size(6, 5);
		pixel_mode = 0;
		repeat (15) send_request(1'b0, next_pixel(0));
		write_frame_size(4, 3);
		finish_frame(0);

		repeat (16) begin
			run_frame(CFG_W'($urandom_range(8, 1)), CFG_W'($urandom_range(6, 1)),
				$urandom_range(2));
		end
		wait_idle();

		$display("Checked %0d results over %0d frames, sizes from 1x1 up to 40 pixels wide",
			sb.checked, frames_done);
		if (sb.pending_q.size() > 0) begin
			sb.mismatches++;
			$display("%0d expected results never arrived", sb.pending_q.size());
		end
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
design/gmd_pkg.sv
design/gmd_if.sv
design/gmd_isqrt.sv
design/gmd_div.sv
design/gmd_ctrl.sv
design/gmd_dp.sv
design/gradient_magnitude_direction_unit.sv
sim/tb_gradient_magnitude_direction_unit.sv
